// File: design/lmp_pkg.sv
// Shared constants, types and table-build states for the LCG jump-ahead multiplier.
package lmp_pkg;

   // Word and exponent widths
   localparam int MULT_WIDTH = 47;
   localparam int EXP_WIDTH  = 32;
   localparam int EXP_BITS   = 32;

   // One pipeline bit stage per exponent bit that counts
   localparam int NUM_STAGES = (EXP_BITS < EXP_WIDTH) ? EXP_BITS : EXP_WIDTH;
   localparam int CNT_WIDTH  = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

   // Split of a 47-bit operand into a low and a high limb for the partial products
   localparam int LO_WIDTH = (MULT_WIDTH + 1) / 2;
   localparam int HI_WIDTH = MULT_WIDTH - LO_WIDTH;

   // Reset value of the multiplier, assembled from its four 12-bit limbs
   localparam int LIMB_SHIFT = 12;
   localparam logic [63:0] MULT_LIMB3 = 64'd1222;
   localparam logic [63:0] MULT_LIMB2 = 64'd1498;
   localparam logic [63:0] MULT_LIMB1 = 64'd712;
   localparam logic [63:0] MULT_LIMB0 = 64'd1645;
   localparam logic [MULT_WIDTH-1:0] BASE_RESET = MULT_WIDTH'(
      (MULT_LIMB3 << (3 * LIMB_SHIFT)) | (MULT_LIMB2 << (2 * LIMB_SHIFT)) |
      (MULT_LIMB1 << LIMB_SHIFT) | MULT_LIMB0);

   typedef logic [MULT_WIDTH-1:0] word_type;
   typedef logic [EXP_WIDTH-1:0]  exp_type;

   // Squares a^(2^k), one per bit stage
   typedef word_type [NUM_STAGES-1:0] square_table_type;

   // Transaction between bit stages
   typedef struct packed {
      exp_type  exponent;
      word_type acc;
   } item_type;

   // Transaction inside a bit stage, with the partial product
   typedef struct packed {
      exp_type  exponent;
      word_type acc;
      word_type prod;
   } part_type;

   // Square table build sequencer
   typedef enum logic [1:0] {
      TBL_LOAD,
      TBL_SQ_LO,
      TBL_SQ_HI,
      TBL_READY
   } tbl_state_type;

endpackage

// File: design/lmp_square_table.sv
// Multiplier register and sequencer that builds the table of repeated squares.
module lmp_square_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [lmp_pkg::MULT_WIDTH-1:0] csr_write_data,
   output lmp_pkg::square_table_type      squares,
   output logic                           table_ready
);
   import lmp_pkg::*;

   logic [MULT_WIDTH-1:0] base_ff;
   tbl_state_type         state_ff, state_in;
   logic [CNT_WIDTH-1:0]  count_ff;
   word_type              cur_ff;
   word_type              part_ff;
   square_table_type      table_ff;

   logic [2*LO_WIDTH-1:0] lo_prod;
   word_type              cross_prod;
   word_type              square_next;

   // Squaring of the current entry: lo*lo, then twice the cross term at bit LO_WIDTH
   assign lo_prod     = cur_ff[LO_WIDTH-1:0] * cur_ff[LO_WIDTH-1:0];
   assign cross_prod  = MULT_WIDTH'(cur_ff[LO_WIDTH-1:0]) *
                        MULT_WIDTH'(cur_ff[MULT_WIDTH-1:LO_WIDTH]);
   assign square_next = part_ff + (cross_prod << (LO_WIDTH + 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TBL_LOAD: begin
            state_in = (NUM_STAGES > 1) ? TBL_SQ_LO : TBL_READY;
         end
         TBL_SQ_LO: begin
            state_in = TBL_SQ_HI;
         end
         TBL_SQ_HI: begin
            state_in = (count_ff == CNT_WIDTH'(NUM_STAGES - 1)) ? TBL_READY : TBL_SQ_LO;
         end
         TBL_READY: begin
            state_in = TBL_READY;
         end
         default: begin
            state_in = TBL_LOAD;
         end
      endcase
      // A new multiplier restarts the build
      if (csr_write_enable) begin
         state_in = TBL_LOAD;
      end
   end

   // Outputs
   always_comb begin
      case (state_ff)
         TBL_READY: table_ready = 1'b1;
         default:   table_ready = 1'b0;
      endcase
   end

   assign squares = table_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_RESET;
         state_ff <= TBL_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            base_ff <= csr_write_data;
         end
         case (state_ff)
            TBL_LOAD:  count_ff <= CNT_WIDTH'(1);
            TBL_SQ_HI: count_ff <= count_ff + 1'b1;
            default:   count_ff <= count_ff;
         endcase
      end
   end

   // Table datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         TBL_LOAD: begin
            cur_ff      <= base_ff;
            table_ff[0] <= base_ff;
         end
         TBL_SQ_LO: begin
            part_ff <= lo_prod[MULT_WIDTH-1:0];
         end
         TBL_SQ_HI: begin
            cur_ff             <= square_next;
            table_ff[count_ff] <= square_next;
         end
         default: begin
            cur_ff <= cur_ff;
         end
      endcase
   end

endmodule

// File: design/lmp_bit_stage.sv
// One exponent bit: conditional multiply of the running product, in three registered steps.
module lmp_bit_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              valid_in,
   input  lmp_pkg::item_type item_in,
   input  lmp_pkg::word_type square,
   output logic              valid_out,
   output lmp_pkg::item_type item_out
);
   import lmp_pkg::*;

   logic     a_valid_ff, b_valid_ff, c_valid_ff;
   part_type a_ff, b_ff;
   item_type c_ff;

   logic [2*LO_WIDTH-1:0] lo_prod;
   word_type              cross_lh;
   word_type              cross_hl;
   word_type              prod_full;

   // Step A: low limb times low limb
   assign lo_prod = item_in.acc[LO_WIDTH-1:0] * square[LO_WIDTH-1:0];

   // Step B: low limb of the product times high limb of the square
   assign cross_lh = MULT_WIDTH'(a_ff.acc[LO_WIDTH-1:0]) *
                     MULT_WIDTH'(square[MULT_WIDTH-1:LO_WIDTH]);

   // Step C: high limb of the product times low limb of the square
   assign cross_hl  = MULT_WIDTH'(b_ff.acc[MULT_WIDTH-1:LO_WIDTH]) *
                      MULT_WIDTH'(square[LO_WIDTH-1:0]);
   assign prod_full = b_ff.prod + (cross_hl << LO_WIDTH);

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= valid_in;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff.exponent <= item_in.exponent;
         a_ff.acc      <= item_in.acc;
         a_ff.prod     <= lo_prod[MULT_WIDTH-1:0];

         b_ff.exponent <= a_ff.exponent;
         b_ff.acc      <= a_ff.acc;
         b_ff.prod     <= a_ff.prod + (cross_lh << LO_WIDTH);

         // Take the product only where this exponent bit is set
         c_ff.acc      <= b_ff.exponent[0] ? prod_full : b_ff.acc;
         c_ff.exponent <= b_ff.exponent >> 1;
      end
   end

   assign valid_out = c_valid_ff;
   assign item_out  = c_ff;

endmodule

// File: design/lcg_multiplier_power_mod2_47_top.sv
// Top level: a^n mod 2^47 by a pipeline of conditional multiplies over precomputed squares.
//
//   channel  direction  handshake                payload
//   req      in         req_valid / req_ready    req_exponent [31:0]
//   rsp      out        rsp_valid / rsp_ready    rsp_power [46:0]
//   csr      in         csr_write_enable         csr_write_data [46:0]
//
// One transaction enters per cycle while the pipeline does not stall; each exponent bit
// takes three multiply steps, followed by the output register.
// After reset, and after every csr write, the square table is rebuilt by one squaring
// unit (a load step, then a low and a high squaring step per later entry); req_ready stays low meanwhile.
// The pipeline stalls only when its last stage and the output register both hold a
// result that is not taken; otherwise new transactions keep entering.
module lcg_multiplier_power_mod2_47_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lmp_pkg::EXP_WIDTH-1:0]  req_exponent,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lmp_pkg::MULT_WIDTH-1:0] rsp_power,
   input  logic                           csr_write_enable,
   input  logic [lmp_pkg::MULT_WIDTH-1:0] csr_write_data
);
   import lmp_pkg::*;

   square_table_type squares;
   logic             table_ready;

   logic             valid_chain [NUM_STAGES+1];
   item_type         item_chain  [NUM_STAGES+1];

   logic             out_free;
   logic             advance;
   logic             rsp_valid_ff;
   word_type         rsp_power_ff;

   // Multiplier register and table of squares
   lmp_square_table u_table (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .squares          (squares),
      .table_ready      (table_ready)
   );

   // Flow control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = out_free || !valid_chain[NUM_STAGES];
   assign req_ready = table_ready && advance;

   // Pipeline entry: running product starts at one
   assign valid_chain[0]         = req_valid && req_ready;
   assign item_chain[0].exponent = req_exponent;
   assign item_chain[0].acc      = MULT_WIDTH'(1);

   // One bit stage per exponent bit
   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_bit
      lmp_bit_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (valid_chain[k]),
         .item_in   (item_chain[k]),
         .square    (squares[k]),
         .valid_out (valid_chain[k+1]),
         .item_out  (item_chain[k+1])
      );
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= valid_chain[NUM_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && valid_chain[NUM_STAGES]) begin
         rsp_power_ff <= item_chain[NUM_STAGES].acc;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_power = rsp_power_ff;

endmodule
